### hdl/assert_macros.svh
// Assertion macros used by the checker file afoe_checker.sv.
// Clock clk_i and active-low reset rst_ni must be visible at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked out of reset only.
`define AFOE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("afoe assertion failed");

// Property checked at every edge, reset included.
`define AFOE_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("afoe assertion failed");

`endif

### hdl/afoe_pkg.sv
// Package for the accumulator/flag operation executor.
// Field widths, operation codes and the item and result types; no dependencies.
`default_nettype none

package afoe_pkg;

  localparam int unsigned FuncW = 5;
  localparam int unsigned AccW  = 8;

  localparam logic [AccW-1:0] AccMask = 8'hFF;
  localparam logic [AccW-1:0] AccOne  = 8'h01;

  typedef enum logic [FuncW-1:0] {
    OpSetC     = 5'd0,
    OpCplC     = 5'd1,
    OpCplA     = 5'd2,
    OpNeg      = 5'd3,
    OpRlc      = 5'd4,
    OpRrc      = 5'd5,
    OpRl       = 5'd6,
    OpRr       = 5'd7,
    OpAddA     = 5'd8,
    OpAdcA     = 5'd9,
    OpClr      = 5'd10,
    OpSbcA     = 5'd11,
    OpTst      = 5'd12,
    OpTst2     = 5'd13,
    OpClr2     = 5'd14,
    OpInc      = 5'd15,
    OpDec      = 5'd16,
    OpLd0      = 5'd17,
    OpLd1      = 5'd18,
    OpCp0      = 5'd19,
    OpCp1      = 5'd20,
    OpAdcZ     = 5'd21,
    OpAnd1     = 5'd22,
    OpOr1      = 5'd23,
    OpXor1     = 5'd24,
    OpXorFF    = 5'd25
  } afoe_op_e;

  typedef struct packed {
    logic [FuncW-1:0] func;
    logic [AccW-1:0]  acc;
    logic             zero;
    logic             carry;
  } afoe_item_t;

  typedef struct packed {
    logic [AccW-1:0] acc;
    logic            zero;
    logic            carry;
  } afoe_res_t;

endpackage

`default_nettype wire

### hdl/afoe_in_if.sv
// Input channel interface: valid/ready handshake with the operation item.
// Depends on afoe_pkg.
`default_nettype none

interface afoe_in_if;
  logic                          valid;
  logic                          ready;
  logic [afoe_pkg::FuncW-1:0]    func;
  logic [afoe_pkg::AccW-1:0]     acc_in;
  logic                          zero_in;
  logic                          carry_in;

  modport source (output valid, output func, output acc_in, output zero_in,
                  output carry_in, input ready);
  modport sink   (input valid, input func, input acc_in, input zero_in,
                  input carry_in, output ready);
endinterface

`default_nettype wire

### hdl/afoe_out_if.sv
// Result channel interface: valid/ready handshake with the new machine state.
// Depends on afoe_pkg.
`default_nettype none

interface afoe_out_if;
  logic                      valid;
  logic                      ready;
  logic [afoe_pkg::AccW-1:0] acc_out;
  logic                      zero_out;
  logic                      carry_out;

  modport source (output valid, output acc_out, output zero_out, output carry_out,
                  input ready);
  modport sink   (input valid, input acc_out, input zero_out, input carry_out,
                  output ready);
endinterface

`default_nettype wire

### hdl/afoe_in_reg.sv
// Input register stage: captures one operation item per transfer.
// Depends on afoe_pkg and afoe_in_if.
`default_nettype none

module afoe_in_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  afoe_in_if.sink              in_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output afoe_pkg::afoe_item_t item_o
);
  import afoe_pkg::*;

  logic       valid_q, valid_d;
  afoe_item_t item_q, item_d;
  logic       load;

  assign in_i.ready = !valid_q || ready_i;
  assign load       = in_i.valid && in_i.ready;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (in_i.ready) begin
      valid_d = in_i.valid;
    end
    if (load) begin
      item_d.func  = in_i.func;
      item_d.acc   = in_i.acc_in;
      item_d.zero  = in_i.zero_in;
      item_d.carry = in_i.carry_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

### hdl/afoe_alu.sv
// Combinational accumulator/flag ALU: one operation on A, Z and C.
// Depends on afoe_pkg.
`default_nettype none

module afoe_alu (
  input  afoe_pkg::afoe_item_t item_i,
  output afoe_pkg::afoe_res_t  res_o
);
  import afoe_pkg::*;

  logic [AccW-1:0] a;
  logic            c;
  logic [AccW:0]   sum_dbl;
  logic [AccW:0]   sum_inc;
  logic [AccW-1:0] neg_a;
  logic            a_zero;

  assign a       = item_i.acc;
  assign c       = item_i.carry;
  assign sum_dbl = {a, 1'b0} + {{AccW{1'b0}}, c};
  assign sum_inc = {1'b0, a} + {{AccW{1'b0}}, c};
  assign neg_a   = ~a + AccOne;
  assign a_zero  = (a == '0);

  always_comb begin
    res_o.acc   = a;
    res_o.zero  = item_i.zero;
    res_o.carry = c;
    case (afoe_op_e'(item_i.func))
      OpSetC: res_o.carry = 1'b1;
      OpCplC: res_o.carry = !c;
      OpCplA: res_o.acc   = ~a;
      OpNeg: begin
        res_o.acc   = neg_a;
        res_o.carry = !a_zero;
        res_o.zero  = a_zero;
      end
      OpRlc: begin
        res_o.acc   = {a[AccW-2:0], a[AccW-1]};
        res_o.carry = a[AccW-1];
      end
      OpRrc: begin
        res_o.acc   = {a[0], a[AccW-1:1]};
        res_o.carry = a[0];
      end
      OpRl: begin
        res_o.acc   = {a[AccW-2:0], c};
        res_o.carry = a[AccW-1];
      end
      OpRr: begin
        res_o.acc   = {c, a[AccW-1:1]};
        res_o.carry = a[0];
      end
      OpAddA: begin
        res_o.acc   = {a[AccW-2:0], 1'b0};
        res_o.carry = a[AccW-1];
        res_o.zero  = (a[AccW-2:0] == '0);
      end
      OpAdcA: begin
        res_o.acc   = sum_dbl[AccW-1:0];
        res_o.carry = sum_dbl[AccW];
        res_o.zero  = (sum_dbl[AccW-1:0] == '0);
      end
      OpClr, OpClr2: begin
        res_o.acc   = '0;
        res_o.zero  = 1'b1;
        res_o.carry = 1'b0;
      end
      OpSbcA: begin
        res_o.acc  = {AccW{c}};
        res_o.zero = !c;
      end
      OpTst, OpTst2, OpCp0: begin
        res_o.zero  = a_zero;
        res_o.carry = 1'b0;
      end
      OpInc: begin
        res_o.acc  = a + AccOne;
        res_o.zero = (a == AccMask);
      end
      OpDec: begin
        res_o.acc  = a - AccOne;
        res_o.zero = (a == AccOne);
      end
      OpLd0: res_o.acc = '0;
      OpLd1: res_o.acc = AccOne;
      OpCp1: begin
        res_o.zero  = (a == AccOne);
        res_o.carry = a_zero;
      end
      OpAdcZ: begin
        res_o.acc   = sum_inc[AccW-1:0];
        res_o.carry = sum_inc[AccW];
        res_o.zero  = (sum_inc[AccW-1:0] == '0);
      end
      OpAnd1: begin
        res_o.acc   = a & AccOne;
        res_o.zero  = !a[0];
        res_o.carry = 1'b0;
      end
      OpOr1: begin
        res_o.acc   = a | AccOne;
        res_o.zero  = 1'b0;
        res_o.carry = 1'b0;
      end
      OpXor1: begin
        res_o.acc   = a ^ AccOne;
        res_o.zero  = (a == AccOne);
        res_o.carry = 1'b0;
      end
      OpXorFF: begin
        res_o.acc   = a ^ AccMask;
        res_o.zero  = (a == AccMask);
        res_o.carry = 1'b0;
      end
      default: ;  // unused codes pass the state through
    endcase
  end

endmodule

`default_nettype wire

### hdl/afoe_out_reg.sv
// Result register stage: holds one result until the sink takes it.
// Depends on afoe_pkg and afoe_out_if.
`default_nettype none

module afoe_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  afoe_pkg::afoe_res_t res_i,
  afoe_out_if.source          out_o
);
  import afoe_pkg::*;

  logic      valid_q, valid_d;
  afoe_res_t res_q, res_d;

  assign ready_o = !valid_q || out_o.ready;

  always_comb begin
    valid_d = valid_q;
    res_d   = res_q;
    if (ready_o) begin
      valid_d = valid_i;
      if (valid_i) begin
        res_d = res_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_o.valid     = valid_q;
  assign out_o.acc_out   = res_q.acc;
  assign out_o.zero_out  = res_q.zero;
  assign out_o.carry_out = res_q.carry;

endmodule

`default_nettype wire

### hdl/accumulator_flag_op_executor.sv
// Channel | dir | handshake   | payload
// in_i    | in  | valid/ready | func[4:0], acc_in[7:0], zero_in, carry_in
// out_o   | out | valid/ready | acc_out[7:0], zero_out, carry_out
//
// One item per cycle while the output is not stalled; path: input register,
// then ALU into the result register. Reset clears both stage valid bits only.
// A stalled output holds its result; the input register still takes an item
// while it is empty, so up to two items are in flight.
// Depends on afoe_pkg, afoe_in_if, afoe_out_if and the afoe_* submodules.
`default_nettype none

module accumulator_flag_op_executor (
  input  logic       clk_i,
  input  logic       rst_ni,
  afoe_in_if.sink    in_i,
  afoe_out_if.source out_o
);
  import afoe_pkg::*;

  logic       op_valid;
  logic       op_ready;
  afoe_item_t op_item;
  afoe_res_t  op_res;

  afoe_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .valid_o (op_valid),
    .ready_i (op_ready),
    .item_o  (op_item)
  );

  afoe_alu u_alu (
    .item_i (op_item),
    .res_o  (op_res)
  );

  afoe_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (op_valid),
    .ready_o (op_ready),
    .res_i   (op_res),
    .out_o   (out_o)
  );

endmodule

`default_nettype wire

### hdl/afoe_checker.sv
// Port-level checks for the executor, bound to the top level.
// Depends on assert_macros.svh and afoe_pkg.
`default_nettype none
`include "assert_macros.svh"

module afoe_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [afoe_pkg::AccW-1:0] out_acc_i,
  input logic                      out_zero_i,
  input logic                      out_carry_i
);

  logic in_xfer;
  logic out_stall;

  assign in_xfer   = in_valid_i && in_ready_i;
  assign out_stall = out_valid_i && !out_ready_i;

  `AFOE_ASSERT(a_out_hold, out_stall |=> out_valid_i)
  `AFOE_ASSERT(a_out_stable, out_stall |=> $stable({out_acc_i, out_zero_i, out_carry_i}))
  `AFOE_ASSERT(a_latency, in_xfer ##1 out_ready_i |=> out_valid_i)
  `AFOE_ASSERT(a_no_spurious, $rose(out_valid_i) |-> $past(in_xfer, 2))
  `AFOE_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !out_valid_i)

endmodule

bind accumulator_flag_op_executor afoe_checker u_afoe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_acc_i   (out_o.acc_out),
  .out_zero_i  (out_o.zero_out),
  .out_carry_i (out_o.carry_out)
);

`default_nettype wire
